[sv/afdd_pkg.sv]
// Shared types, constants and codes for the frame deframer and dispatcher.
// Depends on nothing; every other file of the block imports it.
package afdd_pkg;

    // Frame format
    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [7:0]  SUM_TARGET = 8'hFF;

    // Largest frame whose bytes are passed on, and the size of the id table
    localparam logic [15:0] MAX_FRAME     = 16'd128;
    localparam int          MAX_HANDLERS  = 8;
    localparam int          HANDLER_SLOTS = 8;
    localparam int          ID_W          = 8;
    localparam int          HIDX_W        = 3;
    localparam int          COUNT_W       = 4;
    localparam int          INDEX_W       = 7;
    localparam int          LEN_W         = 16;
    localparam int          CFG_DATA_W    = 64;

    // Configuration register indexes
    localparam logic CFG_HANDLER_IDS   = 1'b0;
    localparam logic CFG_HANDLER_COUNT = 1'b1;

    // End-of-frame status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TOO_LONG   = 2'd1;
    localparam logic [1:0] ST_BAD_SUM    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN_ID = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LEN_HI = 4'b0010,
        PH_LEN_LO = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              found;
        logic [HIDX_W-1:0] index;
    } match_t;

    typedef struct packed {
        logic               is_end;
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [1:0]         frame_status;
        logic [LEN_W-1:0]   frame_length;
        logic [ID_W-1:0]    frame_id;
        logic [HIDX_W-1:0]  handler_index;
        logic               last;
    } result_t;

endpackage

[sv/afdd_id_match.sv]
// Handler table lookup: compares a frame id against the configured id table.
// Depends on afdd_pkg.
module afdd_id_match
    import afdd_pkg::*;
(
    input  logic [CFG_DATA_W-1:0] handler_ids,
    input  logic [COUNT_W-1:0]    handler_count,
    input  logic [ID_W-1:0]       frame_id,
    output match_t                match
);

    logic [COUNT_W-1:0]       count_clamped;
    logic [HANDLER_SLOTS-1:0] hit;

    assign count_clamped = (handler_count > COUNT_W'(MAX_HANDLERS))
                         ? COUNT_W'(MAX_HANDLERS) : handler_count;

    // One comparator per table entry; entries at or above the count never hit.
    always_comb
    begin
        for (int i = 0; i < HANDLER_SLOTS; i++)
        begin
            hit[i] = (COUNT_W'(i) < count_clamped)
                   && (handler_ids[i*ID_W +: ID_W] == frame_id);
        end
    end

    // The lowest matching entry wins.
    always_comb
    begin
        match = '0;
        for (int i = HANDLER_SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                match.found = 1'b1;
                match.index = HIDX_W'(i);
            end
        end
    end

endmodule

[sv/afdd_parser.sv]
// Frame parser: phase tracking, length capture, checksum and result formation.
// Depends on afdd_pkg and afdd_id_match.
module afdd_parser
    import afdd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    input  logic [CFG_DATA_W-1:0] handler_ids,
    input  logic [COUNT_W-1:0]    handler_count,
    output logic                  push,
    output result_t               result
);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] expected_length_reg, expected_length_next;
    logic [LEN_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [ID_W-1:0]  first_byte_reg, first_byte_next;

    logic             in_frame;
    logic [7:0]       sum_total;
    logic [ID_W-1:0]  frame_id;
    match_t           match;

    assign in_frame  = bytes_seen_reg < expected_length_reg;
    assign sum_total = running_sum_reg + rx_byte;
    assign frame_id  = (expected_length_reg != '0) ? first_byte_reg : '0;

    afdd_id_match u_id_match (
        .handler_ids   (handler_ids),
        .handler_count (handler_count),
        .frame_id      (frame_id),
        .match         (match)
    );

    always_comb
    begin
        phase_next           = phase_reg;
        expected_length_next = expected_length_reg;
        bytes_seen_next      = bytes_seen_reg;
        running_sum_next     = running_sum_reg;
        first_byte_next      = first_byte_reg;
        push                 = 1'b0;
        result               = '0;
        result.frame_length  = expected_length_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    expected_length_next = {rx_byte, 8'h00};
                    phase_next           = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    expected_length_next = {expected_length_reg[15:8], rx_byte};
                    bytes_seen_next      = '0;
                    running_sum_next     = '0;
                    first_byte_next      = '0;
                    phase_next           = PH_BODY;
                end
                PH_BODY:
                begin
                    if (in_frame)
                    begin
                        running_sum_next = sum_total;
                        bytes_seen_next  = bytes_seen_reg + LEN_W'(1);
                        if (bytes_seen_reg == '0)
                        begin
                            first_byte_next = rx_byte;
                        end
                        // Bytes beyond the largest frame are summed but not passed on.
                        if (bytes_seen_reg < MAX_FRAME)
                        begin
                            push              = 1'b1;
                            result.data_byte  = rx_byte;
                            result.byte_index = bytes_seen_reg[INDEX_W-1:0];
                        end
                    end
                    else
                    begin
                        // This is the checksum byte: report and go back to hunting.
                        push            = 1'b1;
                        result.is_end   = 1'b1;
                        result.last     = 1'b1;
                        result.frame_id = frame_id;
                        if (expected_length_reg > MAX_FRAME)
                        begin
                            result.frame_status = ST_TOO_LONG;
                        end
                        else if (sum_total != SUM_TARGET)
                        begin
                            result.frame_status = ST_BAD_SUM;
                        end
                        else if (expected_length_reg == '0 || !match.found)
                        begin
                            result.frame_status = ST_UNKNOWN_ID;
                        end
                        else
                        begin
                            result.frame_status  = ST_OK;
                            result.handler_index = match.index;
                        end
                        phase_next       = PH_HUNT;
                        bytes_seen_next  = '0;
                        running_sum_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            expected_length_reg <= '0;
            bytes_seen_reg      <= '0;
            running_sum_reg     <= '0;
            first_byte_reg      <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            expected_length_reg <= expected_length_next;
            bytes_seen_reg      <= bytes_seen_next;
            running_sum_reg     <= running_sum_next;
            first_byte_reg      <= first_byte_next;
        end
    end

    // The byte count never runs past the length inside a frame body.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (bytes_seen_reg <= expected_length_reg))
        else $error("byte count beyond frame length");

    // Every end-of-frame report returns the parser to hunting.
    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && result.is_end) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunt after frame end");

    // Data results only come from positions inside the largest frame.
    a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !result.is_end) |-> (bytes_seen_reg < MAX_FRAME))
        else $error("data result beyond largest frame");

endmodule

[sv/afdd_out_buf.sv]
// Two-entry output buffer: a result register backed by a skid register.
// Depends on afdd_pkg for the result type.
module afdd_out_buf
    import afdd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a result ahead of it");

endmodule

[sv/api_frame_deframer_dispatch_top.sv]
// Top level of the frame deframer and handler dispatcher.
// Depends on afdd_pkg, afdd_parser (with afdd_id_match) and afdd_out_buf.
//
// Usage notes
// The block receives one unescaped byte per transfer on the input channel
// (in_valid, in_ready, rx_byte). It hunts for the start byte, reads a
// big-endian 16-bit length, then the frame bytes, then one checksum byte.
// Each frame byte within the largest frame size gives one data transfer on
// the output channel; the checksum byte gives one end-of-frame report with
// status, length, frame id and the matching handler table entry.
// Throughput is one byte per cycle while in_ready is high. Each result is
// registered in the output buffer from the byte that caused it; bytes that
// give no result (hunting, header bytes) simply update the parser state.
// The output side is a result register backed by a skid register, so input
// is still taken while one result waits; only when both hold a result does
// in_ready drop, and it returns the cycle after the receiver takes a transfer.
// Reset clears the parser to hunting, empties the output buffer and clears both
// configuration registers. Configuration is written through cfg_we, cfg_index and
// cfg_data, only while the block is idle; the user must ensure this, the block does not.
module api_frame_deframer_dispatch_top
    import afdd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_end,
    output logic [7:0]            data_byte,
    output logic [INDEX_W-1:0]    byte_index,
    output logic [1:0]            frame_status,
    output logic [LEN_W-1:0]      frame_length,
    output logic [ID_W-1:0]       frame_id,
    output logic [HIDX_W-1:0]     handler_index,
    output logic                  last
);

    logic [CFG_DATA_W-1:0] handler_ids_reg;
    logic [COUNT_W-1:0]    handler_count_reg;

    logic    accept;
    logic    push;
    logic    space;
    result_t push_data;
    result_t out_data;

    // Configuration registers: written by cfg_we, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handler_ids_reg   <= '0;
            handler_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HANDLER_IDS:   handler_ids_reg   <= cfg_data;
                CFG_HANDLER_COUNT: handler_count_reg <= cfg_data[COUNT_W-1:0];
                default:           handler_ids_reg   <= handler_ids_reg;
            endcase
        end
    end

    // A byte is taken whenever the skid register is free, so a result can
    // always be stored even if the receiver is stalled.
    assign in_ready = space;
    assign accept   = in_valid && in_ready;

    afdd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .handler_ids   (handler_ids_reg),
        .handler_count (handler_count_reg),
        .push          (push),
        .result        (push_data)
    );

    afdd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign is_end        = out_data.is_end;
    assign data_byte     = out_data.data_byte;
    assign byte_index    = out_data.byte_index;
    assign frame_status  = out_data.frame_status;
    assign frame_length  = out_data.frame_length;
    assign frame_id      = out_data.frame_id;
    assign handler_index = out_data.handler_index;
    assign last          = out_data.last;

endmodule
